/* design/ffdp_pkg.sv */
// ffdp_pkg: shared types, widths, codes and reset values for the frame deadline pacer.
// No dependencies; compiled first.
package ffdp_pkg;

    localparam int unsigned CATCH_UP_FRAMES_DEF = 8;

    localparam int unsigned OP_W    = 2;
    localparam int unsigned TIME_W  = 63;
    localparam int unsigned CNT_W   = 32;
    localparam int unsigned CFG_W   = 32;
    localparam int unsigned IDX_W   = 2;
    localparam int unsigned DELTA_W = CFG_W + 1;

    localparam logic [CFG_W-1:0]  WHOLE_RST  = 32'd16666666;
    localparam logic [CFG_W-1:0]  REM_RST    = 32'd4000;
    localparam logic [CFG_W-1:0]  DEN_RST    = 32'd6000;
    localparam logic [TIME_W-1:0] TIME_MAX   = {TIME_W{1'b1}};
    localparam logic [CNT_W-1:0]  CNT_MAX    = {CNT_W{1'b1}};

    typedef enum logic [OP_W-1:0] {
        OP_FRAME  = 2'd0,
        OP_RESUME = 2'd1,
        OP_PAUSE  = 2'd2,
        OP_CLEAR  = 2'd3
    } t_opcode;

    typedef enum logic [IDX_W-1:0] {
        REG_WHOLE     = 2'd0,
        REG_REMAINDER = 2'd1,
        REG_DENOM     = 2'd2
    } t_reg_idx;

    typedef struct packed {
        t_opcode           opcode;
        logic [TIME_W-1:0] now;
    } t_item;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        logic [CFG_W-1:0]  data;
    } t_cfg_wr;

    typedef struct packed {
        logic              running;
        logic [TIME_W-1:0] next_deadline;
        logic              frame_was_late;
        logic              did_resync;
        logic [CNT_W-1:0]  frames_scheduled;
        logic [CNT_W-1:0]  frames_late;
        logic [CNT_W-1:0]  resync_total;
        logic [TIME_W-1:0] worst_lateness;
    } t_result;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

/* design/ffdp_req_if.sv */
// ffdp_req_if: request channel carrying opcode and timestamp.
// Depends on ffdp_pkg for field widths.
interface ffdp_req_if;
    logic                         valid;
    logic                         ready;
    logic [ffdp_pkg::OP_W-1:0]    opcode;
    logic [ffdp_pkg::TIME_W-1:0]  now;

    modport source(output valid, opcode, now, input ready);
    modport sink(input valid, opcode, now, output ready);
endinterface

/* design/ffdp_cfg_if.sv */
// ffdp_cfg_if: configuration write channel (register index and write data).
// Depends on ffdp_pkg for field widths.
interface ffdp_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [ffdp_pkg::IDX_W-1:0]   index;
    logic [ffdp_pkg::CFG_W-1:0]   data;

    modport source(output valid, index, data, input ready);
    modport sink(input valid, index, data, output ready);
endinterface

/* design/ffdp_rsp_if.sv */
// ffdp_rsp_if: result channel with pacing status and metrics.
// Depends on ffdp_pkg for field widths.
interface ffdp_rsp_if;
    logic                         valid;
    logic                         ready;
    logic                         running;
    logic [ffdp_pkg::TIME_W-1:0]  next_deadline;
    logic                         frame_was_late;
    logic                         did_resync;
    logic [ffdp_pkg::CNT_W-1:0]   frames_scheduled;
    logic [ffdp_pkg::CNT_W-1:0]   frames_late;
    logic [ffdp_pkg::CNT_W-1:0]   resync_total;
    logic [ffdp_pkg::TIME_W-1:0]  worst_lateness;

    modport source(output valid, running, next_deadline, frame_was_late, did_resync,
                   frames_scheduled, frames_late, resync_total, worst_lateness,
                   input ready);
    modport sink(input valid, running, next_deadline, frame_was_late, did_resync,
                 frames_scheduled, frames_late, resync_total, worst_lateness,
                 output ready);
endinterface

/* design/ffdp_core.sv */
// ffdp_core: interval registers, pacing state and the combinational next-state update for one request.
// Depends on ffdp_pkg.
module ffdp_core #(
    parameter int unsigned CATCH_UP_FRAMES = ffdp_pkg::CATCH_UP_FRAMES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ffdp_pkg::t_cfg_wr i_cfg_wr,
    input  logic              i_step,
    input  ffdp_pkg::t_item   i_item,
    output ffdp_pkg::t_result o_result
);
    localparam int unsigned TW = ffdp_pkg::TIME_W;
    localparam int unsigned CW = ffdp_pkg::CFG_W;
    localparam int unsigned NW = ffdp_pkg::CNT_W;
    localparam int unsigned DW = ffdp_pkg::DELTA_W;
    // catch-up threshold: rounded-up interval times frame count
    localparam int unsigned K_W   = DW + $clog2(CATCH_UP_FRAMES) + 1;
    localparam int unsigned THR_W = K_W + 1;

    // interval registers and values derived from them at write time
    logic [CW-1:0]    r_whole, r_rem, r_den, n_whole, n_rem, n_den;
    logic [CW-1:0]    r_gap, n_gap;
    logic             r_rem_nz, n_rem_nz;
    logic [K_W-1:0]   r_ceil_k, n_ceil_k;
    logic [DW-1:0]    r_delta2, n_delta2;
    logic [CW-1:0]    r_acc2, n_acc2;
    logic [DW-1:0]    n_ceil;
    logic             n_bump2;

    // pacing state
    logic             r_pacing, n_pacing;
    logic [TW-1:0]    r_deadline, n_deadline;
    logic [CW-1:0]    r_acc, n_acc;
    logic [NW-1:0]    r_sched, n_sched;
    logic [NW-1:0]    r_late, n_late;
    logic [NW-1:0]    r_resync, n_resync;
    logic [TW-1:0]    r_max_late, n_max_late;

    // datapath
    logic             bump, is_late, is_resync, late_flag, resync_flag;
    logic [DW-1:0]    delta;
    logic [CW-1:0]    acc_step;
    logic [TW:0]      dl_sum, rs_sum, diff;
    logic [TW-1:0]    dl_step, rs_deadline, lateness;
    logic [THR_W-1:0] thr;

    always_comb begin
        n_whole = r_whole;
        n_rem   = r_rem;
        n_den   = r_den;
        if (!i_rst_n) begin
            n_whole = ffdp_pkg::WHOLE_RST;
            n_rem   = ffdp_pkg::REM_RST;
            n_den   = ffdp_pkg::DEN_RST;
        end else if (i_cfg_wr.en) begin
            case (i_cfg_wr.index)
                ffdp_pkg::REG_WHOLE:     n_whole = i_cfg_wr.data;
                ffdp_pkg::REG_REMAINDER: n_rem   = i_cfg_wr.data;
                ffdp_pkg::REG_DENOM:     n_den   = i_cfg_wr.data;
                default: ;
            endcase
        end
        // remainder at or above denominator: gap is zero, every frame gets the extra ns if the remainder is nonzero
        n_gap    = (n_rem >= n_den) ? '0 : n_den - n_rem;
        n_rem_nz = |n_rem;
        n_ceil   = {1'b0, n_whole} + DW'(n_rem_nz);
        n_ceil_k = K_W'(n_ceil) * K_W'(CATCH_UP_FRAMES);
        // one interval step starting from an empty accumulator
        n_bump2  = n_rem_nz && (n_gap == '0);
        n_delta2 = {1'b0, n_whole} + DW'(n_bump2);
        n_acc2   = n_bump2 ? '0 : n_rem;
    end

    always_ff @(posedge i_clk) begin
        r_whole  <= n_whole;
        r_rem    <= n_rem;
        r_den    <= n_den;
        r_gap    <= n_gap;
        r_rem_nz <= n_rem_nz;
        r_ceil_k <= n_ceil_k;
        r_delta2 <= n_delta2;
        r_acc2   <= n_acc2;
    end

    always_comb begin
        bump     = r_rem_nz && (r_acc >= r_gap);
        delta    = {1'b0, r_whole} + DW'(bump);
        acc_step = bump ? r_acc - r_gap : r_acc + r_rem;
        dl_sum   = {1'b0, r_deadline} + (TW+1)'(delta);
        dl_step  = dl_sum[TW] ? ffdp_pkg::TIME_MAX : dl_sum[TW-1:0];

        diff      = {1'b0, i_item.now} - {1'b0, r_deadline};
        lateness  = diff[TW-1:0];
        is_late   = !diff[TW] && (|lateness);
        // deadline still behind by more than the threshold after one step
        thr       = THR_W'(r_ceil_k) + THR_W'(delta);
        is_resync = is_late && (lateness > TW'(thr));

        rs_sum      = {1'b0, i_item.now} + (TW+1)'(r_delta2);
        rs_deadline = rs_sum[TW] ? ffdp_pkg::TIME_MAX : rs_sum[TW-1:0];
    end

    always_comb begin
        n_pacing    = r_pacing;
        n_deadline  = r_deadline;
        n_acc       = r_acc;
        n_sched     = r_sched;
        n_late      = r_late;
        n_resync    = r_resync;
        n_max_late  = r_max_late;
        late_flag   = 1'b0;
        resync_flag = 1'b0;
        if (i_step) begin
            case (i_item.opcode)
                ffdp_pkg::OP_FRAME: begin
                    if (r_pacing) begin
                        n_sched = ffdp_pkg::sat_inc(r_sched);
                        if (is_late) begin
                            late_flag = 1'b1;
                            n_late    = ffdp_pkg::sat_inc(r_late);
                            if (lateness > r_max_late) begin
                                n_max_late = lateness;
                            end
                        end
                        if (is_resync) begin
                            resync_flag = 1'b1;
                            n_resync    = ffdp_pkg::sat_inc(r_resync);
                            n_deadline  = rs_deadline;
                            n_acc       = r_acc2;
                        end else begin
                            n_deadline = dl_step;
                            n_acc      = acc_step;
                        end
                    end
                end
                ffdp_pkg::OP_RESUME: begin
                    n_deadline = i_item.now;
                    n_acc      = '0;
                    n_pacing   = 1'b1;
                end
                ffdp_pkg::OP_PAUSE: begin
                    n_pacing = 1'b0;
                end
                ffdp_pkg::OP_CLEAR: begin
                    n_sched    = '0;
                    n_late     = '0;
                    n_resync   = '0;
                    n_max_late = '0;
                end
                default: ;
            endcase
        end

        o_result.running          = n_pacing;
        o_result.next_deadline    = n_pacing ? n_deadline : '0;
        o_result.frame_was_late   = late_flag;
        o_result.did_resync       = resync_flag;
        o_result.frames_scheduled = n_sched;
        o_result.frames_late      = n_late;
        o_result.resync_total     = n_resync;
        o_result.worst_lateness   = n_max_late;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pacing   <= 1'b0;
            r_deadline <= '0;
            r_acc      <= '0;
            r_sched    <= '0;
            r_late     <= '0;
            r_resync   <= '0;
            r_max_late <= '0;
        end else begin
            r_pacing   <= n_pacing;
            r_deadline <= n_deadline;
            r_acc      <= n_acc;
            r_sched    <= n_sched;
            r_late     <= n_late;
            r_resync   <= n_resync;
            r_max_late <= n_max_late;
        end
    end

`ifndef SYNTHESIS
    a_resync_is_late: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.did_resync |-> o_result.frame_was_late)
        else $error("resync flagged on a frame that was not late");

    a_resync_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && resync_flag) |=> (r_acc == $past(r_acc2)))
        else $error("accumulator not restarted on resync");

    a_deadline_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_item.opcode == ffdp_pkg::OP_FRAME && r_pacing && !resync_flag)
        |=> (r_deadline >= $past(r_deadline)))
        else $error("deadline moved backward on a frame");

    a_sched_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_step && i_item.opcode == ffdp_pkg::OP_CLEAR) |=> (r_sched >= $past(r_sched)))
        else $error("scheduled count decreased without a clear");
`endif

endmodule

/* design/fractional_frame_deadline_pacer_top.sv */
// A request accepted into the input register is processed when the output stage can take it,
// and its result lands in the output register, where the sink sees it until it is taken.
// Throughput: one request per cycle while the sink holds o_rsp ready; the pacing state is updated in one pass.
// Reset (i_rst_n low, synchronous): pacing off, deadline, accumulator and metrics cleared,
// interval registers back to 16666666 + 4000/6000 ns; both pipeline stages emptied.
// Configuration writes are always accepted (ready held high) and take effect on the next cycle.
module fractional_frame_deadline_pacer_top #(
    parameter int unsigned CATCH_UP_FRAMES = ffdp_pkg::CATCH_UP_FRAMES_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ffdp_req_if.sink     i_req,
    ffdp_cfg_if.sink     i_cfg,
    ffdp_rsp_if.source   o_rsp
);
    // Two-stage pipe: input register feeds the core, whose result lands in the output
    // register. The state update happens exactly when an item moves from stage one into
    // stage two, so a stalled output never causes a request to be processed twice.
    logic              r_in_valid;
    ffdp_pkg::t_item   r_in_item;
    logic              r_out_valid;
    ffdp_pkg::t_result r_out;

    logic              advance;   // output stage can take a new result
    logic              step;      // stage one request is processed this cycle
    ffdp_pkg::t_cfg_wr cfg_wr;
    ffdp_pkg::t_result n_result;

    assign advance     = !r_out_valid || o_rsp.ready;
    assign step        = r_in_valid && advance;
    // input stage frees up either when empty or when its request moves on
    assign i_req.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_comb begin
        cfg_wr.en    = i_cfg.valid && i_cfg.ready;
        cfg_wr.index = i_cfg.index;
        cfg_wr.data  = i_cfg.data;
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_item.opcode <= ffdp_pkg::t_opcode'(i_req.opcode);
            r_in_item.now    <= i_req.now;
        end
    end

    ffdp_core #(
        .CATCH_UP_FRAMES (CATCH_UP_FRAMES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_wr (cfg_wr),
        .i_step   (step),
        .i_item   (r_in_item),
        .o_result (n_result)
    );

    // output register: holds the result until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_result;
        end
    end

    assign o_rsp.valid            = r_out_valid;
    assign o_rsp.running          = r_out.running;
    assign o_rsp.next_deadline    = r_out.next_deadline;
    assign o_rsp.frame_was_late   = r_out.frame_was_late;
    assign o_rsp.did_resync       = r_out.did_resync;
    assign o_rsp.frames_scheduled = r_out.frames_scheduled;
    assign o_rsp.frames_late      = r_out.frames_late;
    assign o_rsp.resync_total     = r_out.resync_total;
    assign o_rsp.worst_lateness   = r_out.worst_lateness;

endmodule
